### rtl/huffman_canonical_code_builder_defines.svh
// assertion macros for the rtl top level of the canonical code builder
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef HUFFMAN_CANONICAL_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CANONICAL_CODE_BUILDER_DEFINES_SVH

// same-cycle implication
`define HCCB_AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hccb check failed");

// next-cycle implication
`define HCCB_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hccb check failed");

`endif

### rtl/hccb_pkg.sv
// types, codes and default sizes for the canonical huffman code builder
// no dependencies
package hccb_pkg;

    // default configuration
    localparam int ALPHABET_DEF     = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int COUNT_BITS_DEF   = 32;

    // fixed field widths
    localparam int SYM_W    = 8;
    localparam int FREQ_W   = 32;
    localparam int LEN_W    = 8;
    localparam int CODE_W   = 32;
    localparam int CLEN_W   = 6;
    localparam int TOTAL_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [CLEN_W-1:0] CLEN_MAX = 6'd63;

    // operation codes
    localparam logic FN_LOAD = 1'b0;
    localparam logic FN_READ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS_RD,
        S_INS_CHK,
        S_MRG_RDA,
        S_MRG_RDB,
        S_MRG_SUM,
        S_ROOT,
        S_DFS_POP,
        S_DFS_CHK,
        S_DFS_KID,
        S_DFS_KID2,
        S_DFS_LEAF,
        S_RK_RD,
        S_RK_CHK,
        S_CODE_RD,
        S_CODE_WR,
        S_QRY,
        S_RESULT
    } state_t;

    // control from the sequencer to the code generator
    typedef struct packed {
        logic             step;
        logic             first;
        logic [LEN_W-1:0] len;
    } hccb_cg_ctrl_t;

endpackage

### rtl/huffman_canonical_code_builder.sv
// Canonical Huffman code builder for a byte alphabet. A load word (func 0) adds
// its frequency to the symbol's count (count memory read, then write back); a
// load with last set then builds the code and answers with one word that carries
// the build status and the number of distinct symbols. The build is run by one
// sequencer over on-chip memories: a count scan with a read and a check per
// symbol, an insertion sort of the leaves into a work list memory, n - 1 merges
// each reinserting the merged node by a backward walk, a depth-first walk with a
// length-ordered insertion into the ranked table, and a read and a write per
// symbol for code assignment. The work list and ranked insertions, one memory
// port each, set the build time. A read word (func 1) returns the ranked entry.
// Words are taken again as soon as the previous result sits in the output
// register.
// depends on hccb_pkg, hccb_code_gen and the defines header
`include "huffman_canonical_code_builder_defines.svh"

module huffman_canonical_code_builder #(
    parameter int ALPHABET     = hccb_pkg::ALPHABET_DEF,
    parameter int MAX_CODE_LEN = hccb_pkg::MAX_CODE_LEN_DEF,
    parameter int COUNT_BITS   = hccb_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [hccb_pkg::SYM_W-1:0]      symbol,
    input  logic [hccb_pkg::FREQ_W-1:0]     frequency,
    input  logic                            last,
    input  logic [hccb_pkg::SYM_W-1:0]      rank,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hccb_pkg::STATUS_W-1:0]   status,
    output logic [hccb_pkg::SYM_W-1:0]      out_symbol,
    output logic [hccb_pkg::CLEN_W-1:0]     code_length,
    output logic [hccb_pkg::CODE_W-1:0]     code_bits,
    output logic [hccb_pkg::TOTAL_W-1:0]    symbol_total
);
    import hccb_pkg::*;

    localparam int AW    = $clog2(ALPHABET);
    localparam int NAW   = $clog2(2 * ALPHABET);
    localparam int CNT_W = $clog2(ALPHABET + 1);
    localparam int WW    = COUNT_BITS + AW;
    localparam int EW    = WW + NAW;
    localparam int SW    = ((COUNT_BITS > FREQ_W) ? COUNT_BITS : FREQ_W) + 1;
    localparam int STK_W = NAW + LEN_W;
    localparam int RK_W  = LEN_W + SYM_W;
    localparam int NODES = 2 * ALPHABET;

    // memories
    logic [COUNT_BITS-1:0] cnt_mem  [ALPHABET];
    logic [EW-1:0]         wl_mem   [NODES];
    logic [2*NAW-1:0]      kid_mem  [NODES];
    logic [SYM_W-1:0]      leaf_mem [ALPHABET];
    logic [STK_W-1:0]      stk_mem  [NODES];
    logic [RK_W-1:0]       rk_mem   [ALPHABET];
    logic [CODE_W-1:0]     code_mem [ALPHABET];

    logic                  cnt_we;
    logic [AW-1:0]         cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
    logic                  wl_we;
    logic [NAW-1:0]        wl_waddr, wl_raddr;
    logic [EW-1:0]         wl_wdata, wl_rd;
    logic                  kid_we;
    logic [NAW-1:0]        kid_waddr, kid_raddr;
    logic [2*NAW-1:0]      kid_wdata, kid_rd;
    logic                  leaf_we;
    logic [AW-1:0]         leaf_waddr, leaf_raddr;
    logic [SYM_W-1:0]      leaf_wdata, leaf_rd;
    logic                  stk_we;
    logic [NAW-1:0]        stk_waddr, stk_raddr;
    logic [STK_W-1:0]      stk_wdata, stk_rd;
    logic                  rk_we;
    logic [AW-1:0]         rk_waddr, rk_raddr;
    logic [RK_W-1:0]       rk_wdata, rk_rd;
    logic                  code_we;
    logic [AW-1:0]         code_waddr, code_raddr;
    logic [CODE_W-1:0]     code_wdata, code_rd;

    // control and working registers
    state_t                state_reg, state_next;
    logic [ALPHABET-1:0]   cvalid_reg, cvalid_next;
    logic [CNT_W-1:0]      distinct_reg, distinct_next;
    logic [STATUS_W-1:0]   build_result_reg, build_result_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic                  last_reg, last_next;
    logic [SYM_W-1:0]      rank_reg, rank_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      rk_cnt_reg, rk_cnt_next;
    logic [NAW-1:0]        h_reg, h_next;
    logic [NAW-1:0]        t_reg, t_next;
    logic [NAW-1:0]        j_reg, j_next;
    logic [NAW-1:0]        node_reg, node_next;
    logic [NAW-1:0]        sp_reg, sp_next;
    logic [NAW-1:0]        kidlo_reg, kidlo_next;
    logic [LEN_W-1:0]      d_reg, d_next;
    logic [EW-1:0]         new_reg, new_next;
    logic [EW-1:0]         a_reg, a_next;
    logic [RK_W-1:0]       new_rk_reg, new_rk_next;
    logic                  strict_reg, strict_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SYM_W-1:0]      res_sym_reg, res_sym_next;
    logic [CLEN_W-1:0]     res_len_reg, res_len_next;
    logic [CODE_W-1:0]     res_code_reg, res_code_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [SYM_W-1:0]      out_sym_reg, out_sym_next;
    logic [CLEN_W-1:0]     out_len_reg, out_len_next;
    logic [CODE_W-1:0]     out_code_reg, out_code_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;

    // helpers
    logic                  in_acc;
    logic                  out_free;
    logic                  sym_ok;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [SW-1:0]         cnt_sum;
    logic [COUNT_BITS-1:0] cnt_cap;
    logic [WW-1:0]         rd_w, new_w, a_w;
    logic                  ins_move;
    logic [NAW-1:0]        stk_node;
    logic [LEN_W-1:0]      stk_d;
    logic                  is_leaf;
    logic                  lst_one;
    logic                  scan_done;
    logic                  code_done;
    logic [LEN_W-1:0]      q_len;

    hccb_cg_ctrl_t         cg_ctrl;
    logic [CODE_W-1:0]     cg_code;
    logic                  cg_long;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign sym_ok    = (freq_reg != '0) && (TOTAL_W'(sym_reg) < TOTAL_W'(ALPHABET));
    assign cnt_cap   = '1;
    assign rd_w      = wl_rd[EW-1:NAW];
    assign new_w     = new_reg[EW-1:NAW];
    assign a_w       = a_reg[EW-1:NAW];
    assign ins_move  = strict_reg ? (rd_w > new_w) : (rd_w >= new_w);
    assign stk_node  = stk_rd[STK_W-1:LEN_W];
    assign stk_d     = stk_rd[LEN_W-1:0];
    assign is_leaf   = stk_node < NAW'(n_reg);
    assign lst_one   = (t_reg - h_reg) == NAW'(1);
    assign scan_done = (i_reg == CNT_W'(ALPHABET));
    assign code_done = (i_reg == n_reg);
    assign q_len     = rk_rd[RK_W-1:SYM_W];

    // code value unit
    hccb_code_gen #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_code_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cg_ctrl),
        .code     (cg_code),
        .too_long (cg_long)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (func == FN_LOAD) ? S_LOAD : S_QRY;
                end
            end
            S_LOAD:     state_next = last_reg ? S_SCAN_RD : S_IDLE;
            S_SCAN_RD:
            begin
                if (scan_done)
                begin
                    state_next = (n_reg == '0) ? S_RESULT : S_MRG_RDA;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: state_next = (cur_cnt != '0) ? S_INS_RD : S_SCAN_RD;
            S_INS_RD:
            begin
                if (j_reg == h_reg)
                begin
                    state_next = strict_reg ? S_SCAN_RD : S_MRG_RDA;
                end
                else
                begin
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                if (ins_move)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = strict_reg ? S_SCAN_RD : S_MRG_RDA;
                end
            end
            S_MRG_RDA:  state_next = lst_one ? S_ROOT : S_MRG_RDB;
            S_MRG_RDB:  state_next = S_MRG_SUM;
            S_MRG_SUM:  state_next = S_INS_RD;
            S_ROOT:     state_next = S_DFS_POP;
            S_DFS_POP:  state_next = (sp_reg == '0) ? S_CODE_RD : S_DFS_CHK;
            S_DFS_CHK:  state_next = is_leaf ? S_DFS_LEAF : S_DFS_KID;
            S_DFS_KID:  state_next = S_DFS_KID2;
            S_DFS_KID2: state_next = S_DFS_POP;
            S_DFS_LEAF: state_next = S_RK_RD;
            S_RK_RD:    state_next = (j_reg == '0) ? S_DFS_POP : S_RK_CHK;
            S_RK_CHK:
            begin
                state_next = (rk_rd[RK_W-1:SYM_W] > new_rk_reg[RK_W-1:SYM_W])
                             ? S_RK_RD : S_DFS_POP;
            end
            S_CODE_RD:  state_next = code_done ? S_RESULT : S_CODE_WR;
            S_CODE_WR:  state_next = S_CODE_RD;
            S_QRY:      state_next = S_RESULT;
            S_RESULT:   state_next = out_free ? S_IDLE : S_RESULT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cvalid_next       = cvalid_reg;
        distinct_next     = distinct_reg;
        build_result_next = build_result_reg;
        sym_next          = sym_reg;
        freq_next         = freq_reg;
        last_next         = last_reg;
        rank_next         = rank_reg;
        i_next            = i_reg;
        n_next            = n_reg;
        rk_cnt_next       = rk_cnt_reg;
        h_next            = h_reg;
        t_next            = t_reg;
        j_next            = j_reg;
        node_next         = node_reg;
        sp_next           = sp_reg;
        kidlo_next        = kidlo_reg;
        d_next            = d_reg;
        new_next          = new_reg;
        a_next            = a_reg;
        new_rk_next       = new_rk_reg;
        strict_next       = strict_reg;
        res_status_next   = res_status_reg;
        res_sym_next      = res_sym_reg;
        res_len_next      = res_len_reg;
        res_code_next     = res_code_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_status_next   = out_status_reg;
        out_sym_next      = out_sym_reg;
        out_len_next      = out_len_reg;
        out_code_next     = out_code_reg;
        out_total_next    = out_total_reg;

        cnt_we     = 1'b0;
        cnt_waddr  = '0;
        cnt_raddr  = '0;
        cnt_wdata  = '0;
        wl_we      = 1'b0;
        wl_waddr   = '0;
        wl_raddr   = '0;
        wl_wdata   = '0;
        kid_we     = 1'b0;
        kid_waddr  = '0;
        kid_raddr  = '0;
        kid_wdata  = '0;
        leaf_we    = 1'b0;
        leaf_waddr = '0;
        leaf_raddr = '0;
        leaf_wdata = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_raddr  = '0;
        stk_wdata  = '0;
        rk_we      = 1'b0;
        rk_waddr   = '0;
        rk_raddr   = '0;
        rk_wdata   = '0;
        code_we    = 1'b0;
        code_waddr = '0;
        code_raddr = '0;
        code_wdata = '0;
        cur_cnt    = '0;
        cnt_sum    = '0;
        cg_ctrl    = '0;

        unique case (state_reg)
            // take a word and start the table reads
            S_IDLE:
            begin
                if (in_acc)
                begin
                    sym_next   = symbol;
                    freq_next  = frequency;
                    last_next  = last;
                    rank_next  = rank;
                    cnt_raddr  = symbol[AW-1:0];
                    rk_raddr   = rank[AW-1:0];
                    code_raddr = rank[AW-1:0];
                end
            end
            // saturating count update
            S_LOAD:
            begin
                cur_cnt = cvalid_reg[sym_reg[AW-1:0]] ? cnt_rd : '0;
                cnt_sum = SW'(cur_cnt) + SW'(freq_reg);
                if (sym_ok)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = sym_reg[AW-1:0];
                    cnt_wdata = (cnt_sum > SW'(cnt_cap)) ? cnt_cap
                                                         : cnt_sum[COUNT_BITS-1:0];
                    cvalid_next[sym_reg[AW-1:0]] = 1'b1;
                end
                i_next = '0;
                n_next = '0;
                h_next = '0;
            end
            // walk the count table
            S_SCAN_RD:
            begin
                if (scan_done)
                begin
                    cvalid_next   = '0;
                    distinct_next = n_reg;
                    t_next        = NAW'(n_reg);
                    node_next     = NAW'(n_reg);
                    if (n_reg == '0)
                    begin
                        build_result_next = ST_NONE;
                        res_status_next   = ST_NONE;
                        res_sym_next      = '0;
                        res_len_next      = '0;
                        res_code_next     = '0;
                    end
                end
                else
                begin
                    cnt_raddr = i_reg[AW-1:0];
                end
            end
            S_SCAN_CHK:
            begin
                cur_cnt = cvalid_reg[i_reg[AW-1:0]] ? cnt_rd : '0;
                i_next  = i_reg + CNT_W'(1);
                if (cur_cnt != '0)
                begin
                    leaf_we     = 1'b1;
                    leaf_waddr  = n_reg[AW-1:0];
                    leaf_wdata  = SYM_W'(i_reg[AW-1:0]);
                    new_next    = {WW'(cur_cnt), NAW'(n_reg)};
                    j_next      = NAW'(n_reg);
                    n_next      = n_reg + CNT_W'(1);
                    strict_next = 1'b1;
                end
            end
            // insertion into the sorted work list
            S_INS_RD:
            begin
                if (j_reg == h_reg)
                begin
                    wl_we    = 1'b1;
                    wl_waddr = j_reg;
                    wl_wdata = new_reg;
                end
                else
                begin
                    wl_raddr = j_reg - NAW'(1);
                end
            end
            S_INS_CHK:
            begin
                wl_we    = 1'b1;
                wl_waddr = j_reg;
                if (ins_move)
                begin
                    wl_wdata = wl_rd;
                    j_next   = j_reg - NAW'(1);
                end
                else
                begin
                    wl_wdata = new_reg;
                end
            end
            // merge the two lightest nodes
            S_MRG_RDA:
            begin
                wl_raddr = h_reg;
            end
            S_MRG_RDB:
            begin
                a_next   = wl_rd;
                wl_raddr = h_reg + NAW'(1);
            end
            S_MRG_SUM:
            begin
                kid_we      = 1'b1;
                kid_waddr   = node_reg;
                kid_wdata   = {a_reg[NAW-1:0], wl_rd[NAW-1:0]};
                new_next    = {a_w + rd_w, node_reg};
                h_next      = h_reg + NAW'(2);
                j_next      = t_reg;
                t_next      = t_reg + NAW'(1);
                node_next   = node_reg + NAW'(1);
                strict_next = 1'b0;
            end
            // depth-first walk from the root
            S_ROOT:
            begin
                stk_we      = 1'b1;
                stk_waddr   = '0;
                stk_wdata   = {wl_rd[NAW-1:0], LEN_W'(0)};
                sp_next     = NAW'(1);
                rk_cnt_next = '0;
            end
            S_DFS_POP:
            begin
                if (sp_reg == '0)
                begin
                    i_next = '0;
                end
                else
                begin
                    stk_raddr = sp_reg - NAW'(1);
                    sp_next   = sp_reg - NAW'(1);
                end
            end
            S_DFS_CHK:
            begin
                d_next     = stk_d;
                leaf_raddr = stk_node[AW-1:0];
                kid_raddr  = stk_node;
            end
            S_DFS_KID:
            begin
                stk_we     = 1'b1;
                stk_waddr  = sp_reg;
                stk_wdata  = {kid_rd[NAW-1:0], d_reg + LEN_W'(1)};
                sp_next    = sp_reg + NAW'(1);
                kidlo_next = kid_rd[2*NAW-1:NAW];
            end
            S_DFS_KID2:
            begin
                stk_we    = 1'b1;
                stk_waddr = sp_reg;
                stk_wdata = {kidlo_reg, d_reg + LEN_W'(1)};
                sp_next   = sp_reg + NAW'(1);
            end
            S_DFS_LEAF:
            begin
                new_rk_next = {d_reg, leaf_rd};
                j_next      = NAW'(rk_cnt_reg);
                rk_cnt_next = rk_cnt_reg + CNT_W'(1);
            end
            // stable insertion by code length
            S_RK_RD:
            begin
                if (j_reg == '0)
                begin
                    rk_we    = 1'b1;
                    rk_waddr = '0;
                    rk_wdata = new_rk_reg;
                end
                else
                begin
                    rk_raddr = AW'(j_reg - NAW'(1));
                end
            end
            S_RK_CHK:
            begin
                rk_we    = 1'b1;
                rk_waddr = j_reg[AW-1:0];
                if (rk_rd[RK_W-1:SYM_W] > new_rk_reg[RK_W-1:SYM_W])
                begin
                    rk_wdata = rk_rd;
                    j_next   = j_reg - NAW'(1);
                end
                else
                begin
                    rk_wdata = new_rk_reg;
                end
            end
            // canonical code assignment
            S_CODE_RD:
            begin
                if (code_done)
                begin
                    build_result_next = cg_long ? ST_LONG : ST_OK;
                    res_status_next   = cg_long ? ST_LONG : ST_OK;
                    res_sym_next      = '0;
                    res_len_next      = '0;
                    res_code_next     = '0;
                end
                else
                begin
                    rk_raddr = i_reg[AW-1:0];
                end
            end
            S_CODE_WR:
            begin
                cg_ctrl.step  = 1'b1;
                cg_ctrl.first = (i_reg == '0);
                cg_ctrl.len   = q_len;
                code_we       = 1'b1;
                code_waddr    = i_reg[AW-1:0];
                code_wdata    = cg_code;
                i_next        = i_reg + CNT_W'(1);
            end
            // lookup by rank
            S_QRY:
            begin
                res_sym_next  = '0;
                res_len_next  = '0;
                res_code_next = '0;
                if (distinct_reg == '0)
                begin
                    res_status_next = ST_NONE;
                end
                else if (TOTAL_W'(rank_reg) >= TOTAL_W'(distinct_reg))
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    res_status_next = build_result_reg;
                    res_sym_next    = rk_rd[SYM_W-1:0];
                    res_len_next    = (q_len > LEN_W'(CLEN_MAX)) ? CLEN_MAX
                                                                 : q_len[CLEN_W-1:0];
                    res_code_next   = code_rd;
                end
            end
            // hand the result to the output register
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_sym_next    = res_sym_reg;
                    out_len_next    = res_len_reg;
                    out_code_next   = res_code_reg;
                    out_total_next  = TOTAL_W'(distinct_reg);
                end
            end
            default:
            begin
                cg_ctrl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cvalid_reg       <= '0;
            distinct_reg     <= '0;
            build_result_reg <= ST_OK;
            out_valid_reg    <= 1'b0;
            i_reg            <= '0;
            n_reg            <= '0;
            rk_cnt_reg       <= '0;
            h_reg            <= '0;
            t_reg            <= '0;
            j_reg            <= '0;
            node_reg         <= '0;
            sp_reg           <= '0;
            strict_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cvalid_reg       <= cvalid_next;
            distinct_reg     <= distinct_next;
            build_result_reg <= build_result_next;
            out_valid_reg    <= out_valid_next;
            i_reg            <= i_next;
            n_reg            <= n_next;
            rk_cnt_reg       <= rk_cnt_next;
            h_reg            <= h_next;
            t_reg            <= t_next;
            j_reg            <= j_next;
            node_reg         <= node_next;
            sp_reg           <= sp_next;
            strict_reg       <= strict_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        freq_reg       <= freq_next;
        last_reg       <= last_next;
        rank_reg       <= rank_next;
        kidlo_reg      <= kidlo_next;
        d_reg          <= d_next;
        new_reg        <= new_next;
        a_reg          <= a_next;
        new_rk_reg     <= new_rk_next;
        res_status_reg <= res_status_next;
        res_sym_reg    <= res_sym_next;
        res_len_reg    <= res_len_next;
        res_code_reg   <= res_code_next;
        out_status_reg <= out_status_next;
        out_sym_reg    <= out_sym_next;
        out_len_reg    <= out_len_next;
        out_code_reg   <= out_code_next;
        out_total_reg  <= out_total_next;
    end

    // count table
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd <= cnt_mem[cnt_raddr];
    end

    // sorted work list of weight and node
    always_ff @(posedge clk)
    begin
        if (wl_we)
        begin
            wl_mem[wl_waddr] <= wl_wdata;
        end
        wl_rd <= wl_mem[wl_raddr];
    end

    // children of merged nodes
    always_ff @(posedge clk)
    begin
        if (kid_we)
        begin
            kid_mem[kid_waddr] <= kid_wdata;
        end
        kid_rd <= kid_mem[kid_raddr];
    end

    // leaf symbols
    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        leaf_rd <= leaf_mem[leaf_raddr];
    end

    // walk stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd <= stk_mem[stk_raddr];
    end

    // ranked length and symbol
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_waddr] <= rk_wdata;
        end
        rk_rd <= rk_mem[rk_raddr];
    end

    // ranked codes
    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[code_waddr] <= code_wdata;
        end
        code_rd <= code_mem[code_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_symbol   = out_sym_reg;
    assign code_length  = out_len_reg;
    assign code_bits    = out_code_reg;
    assign symbol_total = out_total_reg;

    // checks
    `HCCB_AST_NEXT(a_acc_busy, in_acc, state_reg != S_IDLE)
    `HCCB_AST_IMPL(a_tail_fits, state_reg == S_MRG_SUM, t_reg < NAW'(NODES - 1))
    `HCCB_AST_IMPL(a_stack_fits, state_reg == S_DFS_KID2, sp_reg < NAW'(NODES - 1))
    `HCCB_AST_IMPL(a_rank_fits, state_reg == S_DFS_LEAF, rk_cnt_reg < n_reg)

endmodule

### rtl/hccb_code_gen.sv
// canonical code generator: running code value and too-long flag
// depends on hccb_pkg
module hccb_code_gen #(
    parameter int MAX_CODE_LEN = hccb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hccb_pkg::hccb_cg_ctrl_t      ctrl,
    output logic [hccb_pkg::CODE_W-1:0]  code,
    output logic                         too_long
);
    import hccb_pkg::*;

    localparam int SH_W = $clog2(CODE_W);

    logic [CODE_W-1:0] prev_code_reg;
    logic [LEN_W-1:0]  prev_len_reg;
    logic              long_reg;
    logic [LEN_W-1:0]  diff;
    logic [CODE_W-1:0] inc;
    logic              len_long;

    // next code: 0 if first or wide step, else (prev+1) << step
    always_comb
    begin
        diff     = ctrl.len - prev_len_reg;
        inc      = prev_code_reg + CODE_W'(1);
        len_long = 32'(ctrl.len) > 32'(MAX_CODE_LEN);
        if (ctrl.first)
        begin
            code = '0;
        end
        else if (diff >= LEN_W'(CODE_W))
        begin
            code = '0;
        end
        else
        begin
            code = inc << diff[SH_W-1:0];
        end
    end

    assign too_long = long_reg;

    // history of the previous ranked entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg <= '0;
            prev_len_reg  <= '0;
            long_reg      <= 1'b0;
        end
        else if (ctrl.step)
        begin
            prev_code_reg <= code;
            prev_len_reg  <= ctrl.len;
            long_reg      <= ctrl.first ? len_long : (long_reg | len_long);
        end
    end

endmodule

### test/huffman_canonical_code_builder_test.sv
// self-checking testbench for the canonical huffman code builder
// holds its own code builder model; depends on hccb_pkg and the rtl top level
`timescale 1ns / 100ps

module huffman_canonical_code_builder_test;
    import hccb_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_TARGET = 1200;

    // one result word as the block presents it
    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [SYM_W-1:0]    osym;
        logic [CLEN_W-1:0]   clen;
        logic [CODE_W-1:0]   code;
        logic [TOTAL_W-1:0]  tot;
    } code_entry_t;

    // directed stimulus row, with a typed answer where one is given
    typedef struct packed {
        logic              fn;
        logic [SYM_W-1:0]  sym;
        logic [FREQ_W-1:0] freq;
        logic              lst;
        logic [SYM_W-1:0]  rk;
        logic              typed;
        code_entry_t       ans;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                func;
    logic [SYM_W-1:0]    symbol;
    logic [FREQ_W-1:0]   frequency;
    logic                last;
    logic [SYM_W-1:0]    rank;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    out_symbol;
    logic [CLEN_W-1:0]   code_length;
    logic [CODE_W-1:0]   code_bits;
    logic [TOTAL_W-1:0]  symbol_total;

    huffman_canonical_code_builder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .symbol(symbol), .frequency(frequency), .last(last), .rank(rank),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_symbol(out_symbol), .code_length(code_length),
        .code_bits(code_bits), .symbol_total(symbol_total)
    );

    // model state of the code builder
    logic [63:0] sym_count [256];
    logic [63:0] node_w [511];
    int          kid_lo [511];
    int          kid_hi [511];
    logic [7:0]  leaf_of [256];
    logic [7:0]  rk_sym [256];
    int          rk_len [256];
    logic [63:0] rk_code [256];
    int          built_total = 0;
    logic [1:0]  built_status = ST_OK;

    code_entry_t pending_entries [$];
    int          error_count = 0;
    int          word_count = 0;
    int          build_count = 0;
    int          long_builds = 0;
    int          read_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 28;
    int          recv_idle_pct = 80;
    int          phase = 0;
    int          full_sets = 0;

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // huffman tree, code lengths and canonical codes from the count table
    function automatic void build_codes();
        int wl [$];
        int stk_n [$];
        int stk_d [$];
        int n;
        int nxt;
        int a;
        int b;
        int p;
        int j;
        int nd;
        int d;
        int cnt;
        int diff;
        logic [63:0] w;
        logic [63:0] code;
        logic too_long;
        n = 0;
        for (int s = 0; s < 256; s++)
        begin
            if (sym_count[s] != 0)
            begin
                node_w[n] = sym_count[s];
                leaf_of[n] = s[7:0];
                j = n;
                while (j > 0 && node_w[wl[j-1]] > node_w[n])
                    j--;
                wl.insert(j, n);
                n++;
            end
            sym_count[s] = '0;
        end
        built_total = n;
        build_count++;
        if (n == 0)
        begin
            built_status = ST_NONE;
            return;
        end
        // merge the two lightest, merged node ahead of equal weights
        nxt = n;
        while (wl.size() > 1)
        begin
            a = wl.pop_front();
            b = wl.pop_front();
            w = node_w[a] + node_w[b];
            if (w < node_w[a])
                w = '1;
            node_w[nxt] = w;
            kid_lo[nxt] = a;
            kid_hi[nxt] = b;
            p = 0;
            while (p < wl.size() && node_w[wl[p]] < w)
                p++;
            wl.insert(p, nxt);
            nxt++;
        end
        // left-first walk, leaves placed stably by depth
        cnt = 0;
        stk_n.push_back(wl[0]);
        stk_d.push_back(0);
        while (stk_n.size() > 0)
        begin
            nd = stk_n.pop_back();
            d = stk_d.pop_back();
            if (nd < n)
            begin
                j = cnt;
                while (j > 0 && rk_len[j-1] > d)
                begin
                    rk_len[j] = rk_len[j-1];
                    rk_sym[j] = rk_sym[j-1];
                    j--;
                end
                rk_len[j] = d;
                rk_sym[j] = leaf_of[nd];
                cnt++;
            end
            else
            begin
                stk_n.push_back(kid_hi[nd]);
                stk_d.push_back(d + 1);
                stk_n.push_back(kid_lo[nd]);
                stk_d.push_back(d + 1);
            end
        end
        // canonical codes
        code = '0;
        too_long = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                diff = rk_len[i] - rk_len[i-1];
                code = (diff >= 64) ? 64'd0 : ((code + 64'd1) << diff);
            end
            rk_code[i] = code;
            if (rk_len[i] > MAX_CODE_LEN_DEF)
                too_long = 1'b1;
        end
        built_status = too_long ? ST_LONG : ST_OK;
        if (too_long)
            long_builds++;
    endfunction

    // effect of one accepted word; returns 1 when it yields a result
    function automatic bit predict_word(input logic fn, input logic [7:0] sym,
                                        input logic [31:0] freq, input logic lst,
                                        input logic [7:0] rk, output code_entry_t res);
        logic [63:0] sum;
        res = '0;
        if (fn == FN_LOAD)
        begin
            if (freq != 0)
            begin
                sum = sym_count[sym] + freq;
                sym_count[sym] = (sum > 64'hffff_ffff) ? 64'hffff_ffff : sum;
            end
            if (!lst)
                return 1'b0;
            build_codes();
            res.st = built_status;
            res.tot = built_total[8:0];
            return 1'b1;
        end
        read_count++;
        res.tot = built_total[8:0];
        if (built_total == 0)
            res.st = ST_NONE;
        else if (rk >= built_total)
            res.st = ST_RANGE;
        else
        begin
            res.st = built_status;
            res.osym = rk_sym[rk];
            res.clen = (rk_len[rk] > 63) ? CLEN_MAX : rk_len[rk][5:0];
            res.code = rk_code[rk][31:0];
        end
        return 1'b1;
    endfunction

    // drive one word, wait for acceptance and record its expected result
    task automatic send_word(input logic fn, input logic [7:0] sym, input logic [31:0] freq,
                             input logic lst, input logic [7:0] rk,
                             input logic typed, input code_entry_t ans);
        code_entry_t res;
        int new_phase;
        new_phase = (word_count < ITEM_TARGET / 3) ? 0 :
                    (word_count < 2 * ITEM_TARGET / 3) ? 1 : 2;
        if (new_phase != phase)
        begin
            // hold off until every pending result is out
            in_valid <= 1'b0;
            while (pending_entries.size() > 0)
                @(posedge clk);
            phase = new_phase;
            send_idle_pct = (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 1) ? 28 : 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        symbol <= sym;
        frequency <= freq;
        last <= lst;
        rank <= rk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        word_count++;
        if (predict_word(fn, sym, freq, lst, rk, res))
            pending_entries.push_back(typed ? ans : res);
    endtask

    task automatic send_plain(input logic fn, input logic [7:0] sym, input logic [31:0] freq,
                              input logic lst, input logic [7:0] rk);
        send_word(fn, sym, freq, lst, rk, 1'b0, '0);
    endtask

    function automatic logic [31:0] rand_freq();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'hffff_ffff - $urandom_range(3);
            2: return $urandom_range(1000, 1);
            3: return 32'd1 << $urandom_range(31);
            default: return $urandom_range(20, 1);
        endcase
    endfunction

    // reads following a build, mostly in range
    task automatic read_back(input int reads);
        for (int i = 0; i < reads; i++)
        begin
            if ($urandom_range(3) == 0)
                send_plain(FN_READ, 8'($urandom()), $urandom(), 1'($urandom()),
                           8'($urandom()));
            else
                send_plain(FN_READ, 8'($urandom()), $urandom(), 1'($urandom_range(1)),
                           8'($urandom_range(built_total + 1)));
        end
    endtask

    // directed rows
    dir_row_t dir_rows [20] = '{
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd0, 1'b1, '{ST_NONE, 8'd0, 6'd0, 32'd0, 9'd0}},
        '{FN_LOAD, 8'd3, 32'd0, 1'b1, 8'd0, 1'b1, '{ST_NONE, 8'd0, 6'd0, 32'd0, 9'd0}},
        '{FN_LOAD, 8'd255, 32'hffff_ffff, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd255, 32'd5, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd255, 32'd0, 1'b1, 8'd0, 1'b1, '{ST_OK, 8'd0, 6'd0, 32'd0, 9'd1}},
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd0, 1'b1, '{ST_OK, 8'd255, 6'd0, 32'd0, 9'd1}},
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd1, 1'b1, '{ST_RANGE, 8'd0, 6'd0, 32'd0, 9'd1}},
        '{FN_READ, 8'hff, 32'hffff_ffff, 1'b1, 8'd255, 1'b1,
          '{ST_RANGE, 8'd0, 6'd0, 32'd0, 9'd1}},
        '{FN_LOAD, 8'd0, 32'd1, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd128, 32'd1, 1'b1, 8'd0, 1'b1, '{ST_OK, 8'd0, 6'd0, 32'd0, 9'd2}},
        '{FN_READ, 8'd0, 32'd0, 1'b1, 8'd0, 1'b0, '0},
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd1, 1'b0, '0},
        '{FN_LOAD, 8'd7, 32'hffff_ffff, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd1, 32'd1, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd200, 32'd1, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd64, 32'd2, 1'b0, 8'd0, 1'b0, '0},
        '{FN_LOAD, 8'd255, 32'h8000_0000, 1'b1, 8'd0, 1'b0, '0},
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0, '0},
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd4, 1'b0, '0},
        '{FN_READ, 8'd0, 32'd0, 1'b0, 8'd5, 1'b0, '0}
    };

    // stimulus
    initial
    begin
        int pick;
        int loads;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [31:0] fc;
        logic [7:0] base;
        logic [7:0] order [256];
        logic [7:0] tmp;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_LOAD;
        symbol = '0;
        frequency = '0;
        last = 1'b0;
        rank = '0;
        for (int s = 0; s < 256; s++)
            sym_count[s] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].fn, dir_rows[i].sym, dir_rows[i].freq, dir_rows[i].lst,
                      dir_rows[i].rk, dir_rows[i].typed, dir_rows[i].ans);

        while (word_count < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 3 && full_sets < 2)
            begin
                // whole alphabet in shuffled order
                full_sets++;
                for (int s = 0; s < 256; s++)
                    order[s] = s[7:0];
                for (int s = 255; s > 0; s--)
                begin
                    pick = $urandom_range(s);
                    tmp = order[s];
                    order[s] = order[pick];
                    order[pick] = tmp;
                end
                for (int s = 0; s < 256; s++)
                    send_plain(FN_LOAD, order[s], rand_freq(), s == 255, 8'($urandom()));
                read_back($urandom_range(8, 3));
            end
            else if (pick < 10)
            begin
                // fibonacci weights give a deep chain, past the code limit for the longer runs
                fa = 1;
                fb = 1;
                base = 8'($urandom());
                loads = $urandom_range(40, 30);
                for (int s = 0; s < loads; s++)
                begin
                    send_plain(FN_LOAD, 8'(base + s), fa, s == loads - 1, 8'($urandom()));
                    fc = fa + fb;
                    fa = fb;
                    fb = fc;
                end
                read_back($urandom_range(6, 2));
            end
            else if (pick < 22)
            begin
                // loose words of any shape
                if ($urandom_range(1))
                    send_plain(FN_READ, 8'($urandom()), $urandom(), 1'($urandom()),
                               8'($urandom()));
                else
                    send_plain(FN_LOAD, 8'($urandom()), ($urandom_range(3) == 0) ? 32'd0 :
                               rand_freq(), $urandom_range(7) == 0, 8'($urandom()));
            end
            else
            begin
                // well-formed set with repeats from a narrow window
                loads = $urandom_range(24, 1);
                base = 8'($urandom());
                pick = $urandom_range(40, 2);
                for (int s = 0; s < loads; s++)
                    send_plain(FN_LOAD, 8'(base + $urandom_range(pick)),
                               ($urandom_range(15) == 0) ? 32'd0 : rand_freq(),
                               s == loads - 1, 8'($urandom()));
                read_back($urandom_range(6, 1));
            end
        end

        in_valid <= 1'b0;
        while (pending_entries.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d words: %0d builds (%0d over the length limit), %0d reads",
                 word_count, build_count, long_builds, read_count);
        $display("%0d whole-alphabet sets, %0d mismatches", full_sets, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver stall
    initial out_stall = 1'b0;
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        code_entry_t got;
        code_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, out_symbol, code_length, code_bits, symbol_total};
            if (pending_entries.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word st=%0d sym=%0d len=%0d code=%h tot=%0d",
                         $time, got.st, got.osym, got.clen, got.code, got.tot);
            end
            else
            begin
                want = pending_entries.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch expected st=%0d sym=%0d len=%0d code=%h tot=%0d",
                             $time, want.st, want.osym, want.clen, want.code, want.tot);
                    $display("%0t:          actual   st=%0d sym=%0d len=%0d code=%h tot=%0d",
                             $time, got.st, got.osym, got.clen, got.code, got.tot);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_entries.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
